FILE: rtl/simplex_interp_weights_6d_assert.svh
// assertion macros used by the port-level checker
`ifndef SIMPLEX_INTERP_WEIGHTS_6D_ASSERT_SVH
`define SIMPLEX_INTERP_WEIGHTS_6D_ASSERT_SVH

// same-cycle implication, sampled on clock, idle in reset
`define SIW_ASSERT_IMP(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("siw assertion failed");

// next-cycle implication, sampled on clock, idle in reset
`define SIW_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("siw assertion failed");

`endif

FILE: rtl/siw_pkg.sv
// shared types and constants of the simplex interpolation weight block
`timescale 1ns / 1ps
package siw_pkg;

   localparam int NUM_DIMS  = 6;
   localparam int NUM_VERTS = 7;
   localparam int WB        = 20;
   localparam int IW        = 24;
   localparam int CFG_BITS  = 5;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic signed [WB-1:0] W_MAX = {1'b0, {(WB-1){1'b1}}};
   localparam logic signed [WB-1:0] W_MIN = {1'b1, {(WB-1){1'b0}}};

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_SRCH_RD,
      S_SRCH_CMP,
      S_LO_RD,
      S_HI_RD,
      S_DIV_SET,
      S_DIV,
      S_DIV_END,
      S_SORT_F,
      S_IDX,
      S_VERT,
      S_SORT_V,
      S_OUT
   } state_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_LATCH,
      DP_LOAD,
      DP_RD_SRCH,
      DP_RD_LO,
      DP_RD_HI,
      DP_DIV_SET,
      DP_DIV_STEP,
      DP_DIV_END,
      DP_SORT_F,
      DP_IDX,
      DP_VERT,
      DP_SORT_V
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] dim;
      logic [2:0] k;
   } cmd_type;

   typedef struct packed {
      logic bp_gt_x;
   } stat_type;

   function automatic logic signed [WB-1:0] sat_w(input logic signed [31:0] v);
      logic signed [WB-1:0] r;
      if (v > 32'(W_MAX)) begin
         r = W_MAX;
      end else if (v < 32'(W_MIN)) begin
         r = W_MIN;
      end else begin
         r = WB'(v);
      end
      return r;
   endfunction

endpackage

FILE: rtl/siw_ctrl.sv
// controller state machine that sequences search, divide, sort and output
`timescale 1ns / 1ps
module siw_ctrl #(
   parameter int MAX_POINTS = 16,
   parameter int DIV_STEPS  = 49,
   localparam int PW = $clog2(MAX_POINTS),
   localparam int NW = $clog2(MAX_POINTS + 1),
   localparam int BW = $clog2(DIV_STEPS)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_operation,
   output logic               req_ready,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   input  siw_pkg::stat_type  stat,
   input  logic [NW-1:0]      n_cur,
   output siw_pkg::cmd_type   cmd,
   output logic [PW-1:0]      cell_idx
);
   import siw_pkg::*;

   state_type     state_ff, state_in;
   logic [2:0]    dim_ff;
   logic [2:0]    k_ff;
   logic [PW-1:0] idx_ff;
   logic [BW-1:0] bit_ff;
   logic          srch_last;

   assign srch_last = ((NW+1)'(idx_ff) + (NW+1)'(2)) == (NW+1)'(n_cur);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && req_operation == OP_QUERY) state_in = S_START;
         end
         S_START: state_in = (n_cur == NW'(2)) ? S_LO_RD : S_SRCH_RD;
         S_SRCH_RD: state_in = S_SRCH_CMP;
         S_SRCH_CMP: begin
            if (stat.bp_gt_x || srch_last) state_in = S_LO_RD;
            else state_in = S_SRCH_RD;
         end
         S_LO_RD: state_in = S_HI_RD;
         S_HI_RD: state_in = S_DIV_SET;
         S_DIV_SET: state_in = S_DIV;
         S_DIV: begin
            if (bit_ff == BW'(DIV_STEPS - 1)) state_in = S_DIV_END;
         end
         S_DIV_END: begin
            if (dim_ff == 3'(NUM_DIMS - 1)) state_in = S_SORT_F;
            else state_in = S_START;
         end
         S_SORT_F: begin
            if (k_ff == 3'(NUM_DIMS - 1)) state_in = S_IDX;
         end
         S_IDX: begin
            if (k_ff == 3'(NUM_DIMS - 1)) state_in = S_VERT;
         end
         S_VERT: begin
            if (k_ff == 3'(NUM_VERTS - 1)) state_in = S_SORT_V;
         end
         S_SORT_V: begin
            if (k_ff == 3'(NUM_VERTS - 1)) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready && k_ff == 3'(NUM_VERTS - 1)) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op    = DP_NONE;
      cmd.dim   = dim_ff;
      cmd.k     = k_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = (req_operation == OP_QUERY) ? DP_LATCH : DP_LOAD;
         end
         S_SRCH_RD: cmd.op = DP_RD_SRCH;
         S_LO_RD:   cmd.op = DP_RD_LO;
         S_HI_RD:   cmd.op = DP_RD_HI;
         S_DIV_SET: cmd.op = DP_DIV_SET;
         S_DIV:     cmd.op = DP_DIV_STEP;
         S_DIV_END: cmd.op = DP_DIV_END;
         S_SORT_F:  cmd.op = DP_SORT_F;
         S_IDX:     cmd.op = DP_IDX;
         S_VERT:    cmd.op = DP_VERT;
         S_SORT_V:  cmd.op = DP_SORT_V;
         S_OUT:     rsp_valid = 1'b1;
         default:   cmd.op = DP_NONE;
      endcase
   end

   assign cell_idx = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dim_ff   <= '0;
         k_ff     <= '0;
         idx_ff   <= '0;
         bit_ff   <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            S_IDLE: begin
               dim_ff <= '0;
               k_ff   <= '0;
            end
            S_START: idx_ff <= PW'(1);
            S_SRCH_CMP: begin
               if (!stat.bp_gt_x) idx_ff <= idx_ff + PW'(1);
            end
            S_DIV_SET: bit_ff <= '0;
            S_DIV: bit_ff <= bit_ff + BW'(1);
            S_DIV_END: begin
               dim_ff <= (dim_ff == 3'(NUM_DIMS - 1)) ? 3'd0 : dim_ff + 3'd1;
               k_ff   <= '0;
            end
            S_SORT_F, S_IDX: begin
               k_ff <= (k_ff == 3'(NUM_DIMS - 1)) ? 3'd0 : k_ff + 3'd1;
            end
            S_VERT, S_SORT_V: begin
               k_ff <= (k_ff == 3'(NUM_VERTS - 1)) ? 3'd0 : k_ff + 3'd1;
            end
            S_OUT: begin
               if (rsp_ready) k_ff <= (k_ff == 3'(NUM_VERTS - 1)) ? 3'd0 : k_ff + 3'd1;
            end
            default: ;
         endcase
      end
   end

endmodule

FILE: rtl/siw_datapath.sv
// datapath: breakpoint memory, serial divider, sorters and vertex registers
`timescale 1ns / 1ps
module siw_datapath #(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16,
   localparam int PW = $clog2(MAX_POINTS),
   localparam int NW = $clog2(MAX_POINTS + 1)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [2:0]          csr_index,
   input  logic [4:0]          csr_data,
   input  logic [2:0]          req_dim_select,
   input  logic [3:0]          req_point_index,
   input  logic signed [31:0]  req_breakpoint_value,
   input  logic signed [31:0]  req_coord_0,
   input  logic signed [31:0]  req_coord_1,
   input  logic signed [31:0]  req_coord_2,
   input  logic signed [31:0]  req_coord_3,
   input  logic signed [31:0]  req_coord_4,
   input  logic signed [31:0]  req_coord_5,
   input  siw_pkg::cmd_type    cmd,
   input  logic [PW-1:0]       cell_idx,
   output siw_pkg::stat_type   stat,
   output logic [NW-1:0]       n_cur,
   output logic [23:0]         rsp_vertex_index,
   output logic signed [19:0]  rsp_vertex_weight,
   output logic                rsp_last_vertex
);
   import siw_pkg::*;

   localparam int CB    = COORD_BITS;
   localparam int MW    = CB + 1;
   localparam int DW    = MW + FRAC_BITS;
   localparam int DEPTH = NUM_DIMS * MAX_POINTS;
   localparam int AW    = $clog2(DEPTH);
   localparam int FIW   = NUM_DIMS * PW;

   logic [CFG_BITS-1:0]    points_ff [NUM_DIMS];
   logic [NW-1:0]          n_arr [NUM_DIMS];

   logic signed [CB-1:0]   mem [DEPTH];
   logic signed [CB-1:0]   rdata_ff;
   logic [AW-1:0]          rd_addr;
   logic [AW-1:0]          wr_addr;
   logic                   wr_en;

   logic signed [CB-1:0]   x_ff [NUM_DIMS];
   logic signed [CB-1:0]   lo_ff;

   logic [MW-1:0]          rem_ff;
   logic [MW-1:0]          dvs_ff;
   logic [DW-1:0]          dvd_ff;
   logic [DW-1:0]          quo_ff;
   logic                   neg_ff, den_zero_ff, num_neg_ff, num_zero_ff;

   logic signed [MW-1:0]   num_c, den_c;
   logic [MW:0]            trial_c;
   logic signed [WB-1:0]   frac_c;

   logic signed [WB-1:0]   frac_ff [NUM_DIMS];
   logic signed [WB-1:0]   frac_srt [NUM_DIMS];
   logic [2:0]             ord_ff [NUM_DIMS];
   logic [2:0]             ord_srt [NUM_DIMS];
   logic [PW-1:0]          cell_ff [NUM_DIMS];

   logic [FIW-1:0]         stride_ff [NUM_DIMS];
   logic [FIW-1:0]         run_ff, cur_ff;

   logic [FIW-1:0]         vidx_ff [NUM_VERTS];
   logic [FIW-1:0]         vidx_srt [NUM_VERTS];
   logic signed [WB-1:0]   vw_ff [NUM_VERTS];
   logic signed [WB-1:0]   vw_srt [NUM_VERTS];
   logic signed [WB-1:0]   w_c;

   // breakpoint counts in use, clamped
   always_comb begin
      for (int d = 0; d < NUM_DIMS; d++) begin
         if (points_ff[d] < CFG_BITS'(2)) n_arr[d] = NW'(2);
         else if (int'(points_ff[d]) > MAX_POINTS) n_arr[d] = NW'(MAX_POINTS);
         else n_arr[d] = NW'(points_ff[d]);
      end
   end

   assign n_cur = n_arr[cmd.dim];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int d = 0; d < NUM_DIMS; d++) points_ff[d] <= CFG_BITS'(16);
      end else if (csr_valid && int'(csr_index) < NUM_DIMS) begin
         points_ff[csr_index] <= csr_data;
      end
   end

   // breakpoint memory, at most one write and one read a cycle
   assign wr_en   = (cmd.op == DP_LOAD) && (int'(req_dim_select) < NUM_DIMS)
                    && (int'(req_point_index) < MAX_POINTS);
   assign wr_addr = AW'(int'(req_dim_select) * MAX_POINTS + int'(req_point_index));

   always_comb begin
      if (cmd.op == DP_RD_LO)
         rd_addr = AW'(int'(cmd.dim) * MAX_POINTS + int'(cell_idx) - 1);
      else
         rd_addr = AW'(int'(cmd.dim) * MAX_POINTS + int'(cell_idx));
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= CB'(req_breakpoint_value);
      rdata_ff <= mem[rd_addr];
   end

   assign stat.bp_gt_x = rdata_ff > x_ff[cmd.dim];

   // divider operands and restoring step
   assign num_c   = MW'(x_ff[cmd.dim]) - MW'(lo_ff);
   assign den_c   = MW'(rdata_ff) - MW'(lo_ff);
   assign trial_c = {rem_ff, dvd_ff[DW-1]};

   always_comb begin
      if (den_zero_ff) begin
         if (num_zero_ff) frac_c = '0;
         else frac_c = num_neg_ff ? W_MIN : W_MAX;
      end else if (neg_ff) begin
         if (quo_ff > DW'(2 ** (WB - 1))) frac_c = W_MIN;
         else frac_c = -WB'(quo_ff);
      end else begin
         if (quo_ff > DW'($unsigned(W_MAX))) frac_c = W_MAX;
         else frac_c = WB'(quo_ff);
      end
   end

   // odd-even transposition passes, strict compare keeps them stable
   always_comb begin
      frac_srt = frac_ff;
      ord_srt  = ord_ff;
      for (int j = 0; j < NUM_DIMS - 1; j++) begin
         if ((j % 2) == int'(cmd.k[0]) && frac_ff[j] > frac_ff[j+1]) begin
            frac_srt[j]   = frac_ff[j+1];
            frac_srt[j+1] = frac_ff[j];
            ord_srt[j]    = ord_ff[j+1];
            ord_srt[j+1]  = ord_ff[j];
         end
      end
   end

   always_comb begin
      vidx_srt = vidx_ff;
      vw_srt   = vw_ff;
      for (int j = 0; j < NUM_VERTS - 1; j++) begin
         if ((j % 2) == int'(cmd.k[0]) && vidx_ff[j] > vidx_ff[j+1]) begin
            vidx_srt[j]   = vidx_ff[j+1];
            vidx_srt[j+1] = vidx_ff[j];
            vw_srt[j]     = vw_ff[j+1];
            vw_srt[j+1]   = vw_ff[j];
         end
      end
   end

   // weight of vertex k from the sorted fractions
   always_comb begin
      case (cmd.k)
         3'd0: w_c = frac_ff[0];
         3'd1: w_c = sat_w(32'(frac_ff[1]) - 32'(frac_ff[0]));
         3'd2: w_c = sat_w(32'(frac_ff[2]) - 32'(frac_ff[1]));
         3'd3: w_c = sat_w(32'(frac_ff[3]) - 32'(frac_ff[2]));
         3'd4: w_c = sat_w(32'(frac_ff[4]) - 32'(frac_ff[3]));
         3'd5: w_c = sat_w(32'(frac_ff[5]) - 32'(frac_ff[4]));
         default: w_c = sat_w((32'sd1 <<< FRAC_BITS) - 32'(frac_ff[NUM_DIMS-1]));
      endcase
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_LATCH: begin
            x_ff[0] <= CB'(req_coord_0);
            x_ff[1] <= CB'(req_coord_1);
            x_ff[2] <= CB'(req_coord_2);
            x_ff[3] <= CB'(req_coord_3);
            x_ff[4] <= CB'(req_coord_4);
            x_ff[5] <= CB'(req_coord_5);
            run_ff  <= FIW'(1);
            cur_ff  <= '0;
         end
         DP_RD_HI: lo_ff <= rdata_ff;
         DP_DIV_SET: begin
            dvs_ff      <= den_c[MW-1] ? MW'(-den_c) : MW'(den_c);
            dvd_ff      <= {(num_c[MW-1] ? MW'(-num_c) : MW'(num_c)), FRAC_BITS'(0)};
            rem_ff      <= '0;
            quo_ff      <= '0;
            neg_ff      <= num_c[MW-1] ^ den_c[MW-1];
            den_zero_ff <= (den_c == '0);
            num_neg_ff  <= num_c[MW-1];
            num_zero_ff <= (num_c == '0);
         end
         DP_DIV_STEP: begin
            if (trial_c >= {1'b0, dvs_ff}) begin
               rem_ff <= MW'(trial_c - {1'b0, dvs_ff});
               quo_ff <= {quo_ff[DW-2:0], 1'b1};
            end else begin
               rem_ff <= MW'(trial_c);
               quo_ff <= {quo_ff[DW-2:0], 1'b0};
            end
            dvd_ff <= {dvd_ff[DW-2:0], 1'b0};
         end
         DP_DIV_END: begin
            frac_ff[cmd.dim] <= frac_c;
            cell_ff[cmd.dim] <= cell_idx;
            ord_ff[cmd.dim]  <= cmd.dim;
         end
         DP_SORT_F: begin
            frac_ff <= frac_srt;
            ord_ff  <= ord_srt;
         end
         DP_IDX: begin
            stride_ff[cmd.k] <= run_ff;
            cur_ff <= cur_ff + FIW'(cell_ff[cmd.k] * run_ff);
            run_ff <= FIW'(run_ff * n_arr[cmd.k]);
         end
         DP_VERT: begin
            vidx_ff[cmd.k] <= cur_ff;
            vw_ff[cmd.k]   <= w_c;
            if (cmd.k != 3'(NUM_VERTS - 1)) cur_ff <= cur_ff - stride_ff[ord_ff[cmd.k]];
         end
         DP_SORT_V: begin
            vidx_ff <= vidx_srt;
            vw_ff   <= vw_srt;
         end
         default: ;
      endcase
   end

   assign rsp_vertex_index  = IW'(vidx_ff[cmd.k]);
   assign rsp_vertex_weight = vw_ff[cmd.k];
   assign rsp_last_vertex   = (cmd.k == 3'(NUM_VERTS - 1));

endmodule

FILE: rtl/simplex_interp_weights_6d.sv
// top level of the six-dimensional simplex interpolation weight block
`timescale 1ns / 1ps
// Six-dimensional Kuhn simplex interpolation. A load beat (operation 0) writes
// one breakpoint into the per-dimension lists. A query beat (operation 1)
// returns seven rsp beats, (vertex index, weight) pairs in ascending index
// order, the seventh marked by rsp_last_vertex. The block works on one query
// at a time: req_ready is low from the query beat until the last rsp beat is
// taken. The query time is set by the breakpoint memory, which the cell search
// of each dimension probes entry by entry, and by the restoring divider, one
// quotient bit per cycle, shared by the six dimensions; rsp stalls add to it.
// Configuration beats on csr_ are taken every cycle and must only come while
// the block is idle. The breakpoint memory has no reset; every entry a query
// reaches must have been loaded first.
module simplex_interp_weights_6d #(
   parameter int MAX_POINTS = 16,
   parameter int COORD_BITS = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   // configuration write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [4:0]         csr_data,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_operation,
   input  logic [2:0]         req_dim_select,
   input  logic [3:0]         req_point_index,
   input  logic signed [31:0] req_breakpoint_value,
   input  logic signed [31:0] req_coord_0,
   input  logic signed [31:0] req_coord_1,
   input  logic signed [31:0] req_coord_2,
   input  logic signed [31:0] req_coord_3,
   input  logic signed [31:0] req_coord_4,
   input  logic signed [31:0] req_coord_5,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [23:0]        rsp_vertex_index,
   output logic signed [19:0] rsp_vertex_weight,
   output logic               rsp_last_vertex
);
   import siw_pkg::*;

   localparam int PW = $clog2(MAX_POINTS);
   localparam int NW = $clog2(MAX_POINTS + 1);
   // quotient bits per fraction: magnitude plus fraction scaling
   localparam int DIV_STEPS = COORD_BITS + 1 + FRAC_BITS;

   cmd_type       cmd;
   stat_type      stat;
   logic [NW-1:0] n_cur;
   logic [PW-1:0] cell_idx;

   // register writes never stall
   assign csr_ready = 1'b1;

   siw_ctrl #(
      .MAX_POINTS (MAX_POINTS),
      .DIV_STEPS  (DIV_STEPS)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .stat          (stat),
      .n_cur         (n_cur),
      .cmd           (cmd),
      .cell_idx      (cell_idx)
   );

   siw_datapath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_index            (csr_index),
      .csr_data             (csr_data),
      .req_dim_select       (req_dim_select),
      .req_point_index      (req_point_index),
      .req_breakpoint_value (req_breakpoint_value),
      .req_coord_0          (req_coord_0),
      .req_coord_1          (req_coord_1),
      .req_coord_2          (req_coord_2),
      .req_coord_3          (req_coord_3),
      .req_coord_4          (req_coord_4),
      .req_coord_5          (req_coord_5),
      .cmd                  (cmd),
      .cell_idx             (cell_idx),
      .stat                 (stat),
      .n_cur                (n_cur),
      .rsp_vertex_index     (rsp_vertex_index),
      .rsp_vertex_weight    (rsp_vertex_weight),
      .rsp_last_vertex      (rsp_last_vertex)
   );

endmodule

FILE: rtl/siw_checker.sv
// port-level checker of the interpolation block and its bind
`timescale 1ns / 1ps
`include "simplex_interp_weights_6d_assert.svh"
module siw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [23:0] rsp_vertex_index,
   input logic        rsp_last_vertex
);
   import siw_pkg::*;

   // a query beat closes the request side until its results are out
   `SIW_ASSERT_NXT(a_query_blocks, req_valid && req_ready && req_operation == OP_QUERY, !req_ready)
   // results never overlap an open request side
   `SIW_ASSERT_IMP(a_one_at_a_time, rsp_valid, !req_ready)
   // the last beat of a query ends the result burst
   `SIW_ASSERT_NXT(a_last_ends, rsp_valid && rsp_ready && rsp_last_vertex, !rsp_valid)
   // a stalled result beat holds
   `SIW_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_vertex_index))

endmodule

bind simplex_interp_weights_6d siw_checker u_siw_checker (.*);
